### design/ncaa_pkg.sv
package ncaa_pkg;

    // default sizing of the block
    localparam int MAX_CENTROIDS_DEF = 16;
    localparam int MAX_DIMS_DEF      = 16;
    localparam int COORD_BITS_DEF    = 16;

    // fixed field widths
    localparam int SEL_W     = 4;
    localparam int VALUE_W   = 16;
    localparam int LABEL_W   = 4;
    localparam int DIST_W    = 36;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CENTROIDS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT        = 1'b1;

    // item function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_POINT = 1'b1;

    // largest accumulated distance
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // accumulator memory control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } acc_ctl_t;

endpackage

### design/ncaa_store.sv
module ncaa_store
    import ncaa_pkg::*;
#(
    parameter int DEPTH = MAX_CENTROIDS_DEF * MAX_DIMS_DEF,
    parameter int WIDTH = COORD_BITS_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // centroid coordinates, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/ncaa_acc.sv
module ncaa_acc
    import ncaa_pkg::*;
#(
    parameter int DEPTH = MAX_CENTROIDS_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  acc_ctl_t          ctl,
    input  logic [AW-1:0]     rd_addr,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DIST_W-1:0] wr_data,
    output logic [DIST_W-1:0] rd_data
);

    logic [DIST_W-1:0] mem [DEPTH];
    logic [DIST_W-1:0] rd_data_reg;
    logic [DEPTH-1:0]  valid_reg;
    logic [DEPTH-1:0]  valid_next;

    // accumulator storage; an entry not written since the last clear reads as zero
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    // per-entry valid bits, cleared together at the end of a point
    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clear)
        begin
            valid_next = '0;
        end
        else if (ctl.wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/ncaa_engine.sv
module ncaa_engine
    import ncaa_pkg::*;
#(
    parameter int MAX_CENTROIDS = MAX_CENTROIDS_DEF,
    parameter int MAX_DIMS      = MAX_DIMS_DEF,
    parameter int COORD_BITS    = COORD_BITS_DEF,
    localparam int VW  = (COORD_BITS < VALUE_W) ? COORD_BITS : VALUE_W,
    localparam int CIW = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1,
    localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
    localparam int SDEPTH = MAX_CENTROIDS * MAX_DIMS,
    localparam int SAW = (SDEPTH > 1) ? $clog2(SDEPTH) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input item
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic [SEL_W-1:0]   centroid_sel,
    input  logic [SEL_W-1:0]   dim_sel,
    input  logic [VALUE_W-1:0] value,
    input  logic               last_coord,
    // configuration
    input  logic [CNT_W-1:0]   active_centroids,
    input  logic [CNT_W-1:0]   dim_count,
    // centroid store
    output logic               store_we,
    output logic [SAW-1:0]     store_waddr,
    output logic [VW-1:0]      store_wdata,
    output logic               store_re,
    output logic [SAW-1:0]     store_raddr,
    input  logic [VW-1:0]      store_rdata,
    // accumulator memory
    output acc_ctl_t           acc_ctl,
    output logic [CIW-1:0]     acc_raddr,
    output logic [CIW-1:0]     acc_waddr,
    output logic [DIST_W-1:0]  acc_wdata,
    input  logic [DIST_W-1:0]  acc_rdata,
    // result item
    output logic               out_valid,
    input  logic               out_stall,
    output logic [LABEL_W-1:0] label,
    output logic [DIST_W-1:0]  min_distance
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam int IW    = 9;
    localparam int SQW   = 2 * VW + 2;
    localparam int SUM_W = DIST_W + 1;
    localparam int AMW   = 17;

    localparam logic [IW-1:0] MAXC = IW'(MAX_CENTROIDS);
    localparam logic [IW-1:0] MAXD = IW'(MAX_DIMS);

    logic [1:0]         state_reg, state_next;
    logic [CIW-1:0]     c_reg, c_next;
    logic               v1_reg, v2_reg;
    logic [CIW-1:0]     c1_reg, c2_reg;
    logic               out_valid_reg, out_valid_next;

    logic signed [VW-1:0] val_reg;
    logic [DIW-1:0]     d_reg;
    logic               add_en_reg;
    logic               last_reg;
    logic [SQW-1:0]     sq_reg;
    logic [DIST_W-1:0]  best_dist_reg;
    logic [CIW-1:0]     best_idx_reg;
    logic [LABEL_W-1:0] label_reg;
    logic [DIST_W-1:0]  dist_reg;

    logic               accept;
    logic               out_free;
    logic               finish_go;
    logic [IW-1:0]      nc_eff, nd_eff;
    logic [IW-1:0]      cc_w, dc_w;
    logic [IW-1:0]      csel_w, dsel_w, c_w, best_w;
    logic               load_ok;
    logic               sweep_end;
    logic signed [VW:0]   diff;
    logic signed [SQW-1:0] sq_full;
    logic [SUM_W-1:0]   sum_w;
    logic [DIST_W-1:0]  sum_sat;
    logic [AMW-1:0]     waddr_w, raddr_w;

    // effective counts: zero means one, above the maximum means the maximum
    always_comb
    begin
        cc_w = IW'(active_centroids);
        dc_w = IW'(dim_count);
        if (cc_w == '0)
        begin
            nc_eff = IW'(1);
        end
        else if (cc_w > MAXC)
        begin
            nc_eff = MAXC;
        end
        else
        begin
            nc_eff = cc_w;
        end
        if (dc_w == '0)
        begin
            nd_eff = IW'(1);
        end
        else if (dc_w > MAXD)
        begin
            nd_eff = MAXD;
        end
        else
        begin
            nd_eff = dc_w;
        end
    end

    // input handshake
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign csel_w   = IW'(centroid_sel);
    assign dsel_w   = IW'(dim_sel);
    assign load_ok  = (csel_w < MAXC) && (dsel_w < MAXD);

    // centroid load goes straight into the store
    assign waddr_w     = AMW'(csel_w) * AMW'(MAX_DIMS) + AMW'(dsel_w);
    assign store_we    = accept && (func == FUNC_LOAD) && load_ok;
    assign store_waddr = waddr_w[SAW-1:0];
    assign store_wdata = value[VW-1:0];

    // sweep issues one centroid per cycle
    assign c_w         = IW'(c_reg);
    assign sweep_end   = (c_w + IW'(1)) == nc_eff;
    assign raddr_w     = AMW'(c_reg) * AMW'(MAX_DIMS) + AMW'(d_reg);
    assign store_re    = (state_reg == ST_SWEEP);
    assign store_raddr = raddr_w[SAW-1:0];

    assign out_free  = !out_valid_reg || !out_stall;
    assign finish_go = (state_reg == ST_FINISH) && out_free;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        c_next     = c_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (func == FUNC_POINT))
                begin
                    state_next = ST_SWEEP;
                    c_next     = '0;
                end
            end
            ST_SWEEP:
            begin
                if (sweep_end)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    c_next = c_reg + CIW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = last_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            c_reg         <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            c_reg         <= c_next;
            v1_reg        <= (state_reg == ST_SWEEP);
            v2_reg        <= v1_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // subtract and square on the centroid read back from the store
    assign diff    = $signed({val_reg[VW-1], val_reg})
                   - $signed({store_rdata[VW-1], store_rdata});
    assign sq_full = diff * diff;

    // accumulate with saturation
    assign sum_w   = {1'b0, acc_rdata} + SUM_W'(sq_reg);
    assign sum_sat = sum_w[DIST_W] ? DIST_MAX : sum_w[DIST_W-1:0];

    // accumulator memory access: read one stage after the store, write one later
    always_comb
    begin
        acc_ctl.rd_en = v1_reg;
        acc_ctl.wr_en = v2_reg;
        acc_ctl.clear = finish_go;
    end
    assign acc_raddr = c1_reg;
    assign acc_waddr = c2_reg;
    assign acc_wdata = sum_sat;

    assign best_w = IW'(best_idx_reg);

    // item fields, pipeline payload, running minimum and result
    always_ff @(posedge clk)
    begin
        if (accept && (func == FUNC_POINT))
        begin
            val_reg    <= $signed(value[VW-1:0]);
            d_reg      <= dsel_w[DIW-1:0];
            add_en_reg <= dsel_w < nd_eff;
            last_reg   <= last_coord;
        end
        c1_reg <= c_reg;
        c2_reg <= c1_reg;
        sq_reg <= add_en_reg ? SQW'(unsigned'(sq_full)) : '0;
        if (v2_reg)
        begin
            if ((c2_reg == '0) || (sum_sat < best_dist_reg))
            begin
                best_dist_reg <= sum_sat;
                best_idx_reg  <= c2_reg;
            end
        end
        if (finish_go)
        begin
            label_reg <= best_w[LABEL_W-1:0];
            dist_reg  <= best_dist_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign label        = label_reg;
    assign min_distance = dist_reg;

endmodule

### design/nearest_centroid_assign_top.sv
// Nearest-centroid assignment (k-means assignment step, squared Euclidean distance).
// Load items (func 0) write one signed coordinate of one centroid and do not stall the input.
// Point items (func 1) stream one coordinate each; every point coordinate stalls the
// input while the single subtract-square-accumulate unit walks the active centroids
// one per cycle through the centroid memory and the accumulator memory, and the
// coordinate that carries last_coord then also hands its label and min_distance to
// the output register. A result that waits on out_stall does not hold up new items
// until the next result is ready.
// Accumulators clear at once on reset and after each point; the centroid memory
// has no reset and must be loaded before it is used.
module nearest_centroid_assign_top
    import ncaa_pkg::*;
#(
    parameter int MAX_CENTROIDS = MAX_CENTROIDS_DEF,
    parameter int MAX_DIMS      = MAX_DIMS_DEF,
    parameter int COORD_BITS    = COORD_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data,
    // input items
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 func,
    input  logic [SEL_W-1:0]     centroid_sel,
    input  logic [SEL_W-1:0]     dim_sel,
    input  logic [VALUE_W-1:0]   value,
    input  logic                 last_coord,
    // result items
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [LABEL_W-1:0]   label,
    output logic [DIST_W-1:0]    min_distance
);

    localparam int VW     = (COORD_BITS < VALUE_W) ? COORD_BITS : VALUE_W;
    localparam int CIW    = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
    localparam int SDEPTH = MAX_CENTROIDS * MAX_DIMS;
    localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;

    logic [CNT_W-1:0]  active_centroids_reg;
    logic [CNT_W-1:0]  dim_count_reg;

    logic              store_we;
    logic [SAW-1:0]    store_waddr;
    logic [VW-1:0]     store_wdata;
    logic              store_re;
    logic [SAW-1:0]    store_raddr;
    logic [VW-1:0]     store_rdata;

    acc_ctl_t          acc_ctl;
    logic [CIW-1:0]    acc_raddr;
    logic [CIW-1:0]    acc_waddr;
    logic [DIST_W-1:0] acc_wdata;
    logic [DIST_W-1:0] acc_rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_centroids_reg <= CNT_W'(1);
            dim_count_reg        <= CNT_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ACTIVE_CENTROIDS:
                begin
                    active_centroids_reg <= cfg_data;
                end
                REG_DIM_COUNT:
                begin
                    dim_count_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // centroid coordinate memory
    ncaa_store #(
        .DEPTH (SDEPTH),
        .WIDTH (VW)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_we),
        .wr_addr (store_waddr),
        .wr_data (store_wdata),
        .rd_en   (store_re),
        .rd_addr (store_raddr),
        .rd_data (store_rdata)
    );

    // per-centroid distance accumulators
    ncaa_acc #(
        .DEPTH (MAX_CENTROIDS)
    ) u_acc (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (acc_ctl),
        .rd_addr (acc_raddr),
        .wr_addr (acc_waddr),
        .wr_data (acc_wdata),
        .rd_data (acc_rdata)
    );

    // sequencer and arithmetic
    ncaa_engine #(
        .MAX_CENTROIDS (MAX_CENTROIDS),
        .MAX_DIMS      (MAX_DIMS),
        .COORD_BITS    (COORD_BITS)
    ) u_engine (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .func             (func),
        .centroid_sel     (centroid_sel),
        .dim_sel          (dim_sel),
        .value            (value),
        .last_coord       (last_coord),
        .active_centroids (active_centroids_reg),
        .dim_count        (dim_count_reg),
        .store_we         (store_we),
        .store_waddr      (store_waddr),
        .store_wdata      (store_wdata),
        .store_re         (store_re),
        .store_raddr      (store_raddr),
        .store_rdata      (store_rdata),
        .acc_ctl          (acc_ctl),
        .acc_raddr        (acc_raddr),
        .acc_waddr        (acc_waddr),
        .acc_wdata        (acc_wdata),
        .acc_rdata        (acc_rdata),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .label            (label),
        .min_distance     (min_distance)
    );

endmodule

### design/ncaa_checker.sv
module ncaa_checker
    import ncaa_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 func,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [LABEL_W-1:0]   label,
    input logic [DIST_W-1:0]    min_distance
);

    // a point coordinate keeps the block busy for its sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (func == FUNC_POINT)) |=> in_stall)
        else $error("point item did not start a sweep");

    // a centroid load finishes in its own cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (func == FUNC_LOAD)) |=> !in_stall)
        else $error("centroid load held the input");

    // a new result appears only at the end of a busy stretch
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a point in progress");

    // a waiting result stays
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result dropped");

    // a waiting result keeps its fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(label) && $stable(min_distance)))
        else $error("stalled result changed");

endmodule

bind nearest_centroid_assign_top ncaa_checker u_checker (.*);
